>>> design/b64e_pkg.sv
// shared types, constants and helper functions for the base64/32/16 text encoder
// no dependencies; imported by the front, queue and back modules

package b64e_pkg;

    localparam logic [1:0] MODE_B64 = 2'd0;
    localparam logic [1:0] MODE_B32 = 2'd1;
    localparam logic [1:0] MODE_B16 = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // one gathered group, first byte in the top bits, zero-filled below
    typedef struct packed {
        logic [39:0] data;
        logic [3:0]  nchar;
        logic [1:0]  mode;
        logic        eom;
    } grp_t;

    function automatic logic [2:0] group_size(input logic [1:0] mode);
        logic [2:0] g;
        unique case (mode)
            MODE_B64: g = 3'd3;
            MODE_B32: g = 3'd5;
            default:  g = 3'd1;
        endcase
        return g;
    endfunction

    // ceil(8n/w) for a group of n bytes
    function automatic logic [3:0] char_count(input logic [1:0] mode, input logic [2:0] n);
        logic [3:0] c;
        unique case (mode)
            MODE_B64: begin
                unique case (n)
                    3'd1:    c = 4'd2;
                    3'd2:    c = 4'd3;
                    default: c = 4'd4;
                endcase
            end
            MODE_B32: begin
                unique case (n)
                    3'd1:    c = 4'd2;
                    3'd2:    c = 4'd4;
                    3'd3:    c = 4'd5;
                    3'd4:    c = 4'd7;
                    default: c = 4'd8;
                endcase
            end
            default: c = 4'd2;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] top_index(input logic [39:0] data, input logic [1:0] mode);
        logic [5:0] idx;
        unique case (mode)
            MODE_B64: idx = data[39:34];
            MODE_B32: idx = {1'b0, data[39:35]};
            default:  idx = {2'b00, data[39:36]};
        endcase
        return idx;
    endfunction

    function automatic logic [39:0] shift_out(input logic [39:0] data, input logic [1:0] mode);
        logic [39:0] r;
        unique case (mode)
            MODE_B64: r = {data[33:0], 6'd0};
            MODE_B32: r = {data[34:0], 5'd0};
            default:  r = {data[35:0], 4'd0};
        endcase
        return r;
    endfunction

    // alphabet A-Z a-z 0-9 + /
    function automatic logic [6:0] sym_of(input logic [5:0] idx);
        logic [6:0] x;
        logic [6:0] c;
        x = {1'b0, idx};
        if (idx < 6'd26) begin
            c = 7'd65 + x;
        end else if (idx < 6'd52) begin
            c = 7'd71 + x;
        end else if (idx < 6'd62) begin
            c = x - 7'd4;
        end else if (idx == 6'd62) begin
            c = 7'd43;
        end else begin
            c = 7'd47;
        end
        return c;
    endfunction

endpackage

>>> design/b64e_front.sv
// front end: holds the mode register, gathers input bytes into groups
// depends on b64e_pkg; pushes finished groups into b64e_queue

module b64e_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_message
    output logic               push_valid,
    input  logic               push_ready,
    output b64e_pkg::grp_t     push_item
);
    import b64e_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] pend_reg, pend_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        accept;
    logic [2:0]  n;
    logic [39:0] acc;
    logic [39:0] aligned;
    logic        done;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;
    assign n        = cnt_reg + 3'd1;
    assign acc      = {pend_reg, s_tdata};
    assign done     = s_tlast || (n >= group_size(mode_reg));

    always_comb begin
        unique case (n)
            3'd1:    aligned = {acc[7:0], 32'd0};
            3'd2:    aligned = {acc[15:0], 24'd0};
            3'd3:    aligned = {acc[23:0], 16'd0};
            3'd4:    aligned = {acc[31:0], 8'd0};
            default: aligned = acc;
        endcase
    end

    assign push_valid      = accept && done;
    assign push_item.data  = aligned;
    assign push_item.nchar = char_count(mode_reg, n);
    assign push_item.mode  = mode_reg;
    assign push_item.eom   = s_tlast;

    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
            pend_next = '0;
            cnt_next  = '0;
        end else if (accept) begin
            if (done) begin
                pend_next = '0;
                cnt_next  = '0;
            end else begin
                pend_next = acc[31:0];
                cnt_next  = n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_B64;
            pend_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> design/b64e_queue.sv
// short group queue between the front and back ends
// depends on b64e_pkg for the group type

module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  b64e_pkg::grp_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output b64e_pkg::grp_t pop_item
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    grp_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> design/b64e_back.sv
// back end: splits queued groups into indices and drives the output register
// depends on b64e_pkg; pops groups from b64e_queue

module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  b64e_pkg::grp_t pop_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [6:0] out_char, [7] zero
    output logic           m_tlast    // last_char
);
    import b64e_pkg::*;

    logic [39:0] shift_reg, shift_next;
    logic [3:0]  left_reg, left_next;
    logic [1:0]  mode_reg, mode_next;
    logic        eom_reg, eom_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    always_comb begin
        shift_next    = shift_reg;
        left_next     = left_reg;
        mode_next     = mode_reg;
        eom_next      = eom_reg;
        m_tvalid_next = m_tvalid_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        pop_ready     = 1'b0;
        if (out_free) begin
            if (left_reg != '0) begin
                char_next     = sym_of(top_index(shift_reg, mode_reg));
                shift_next    = shift_out(shift_reg, mode_reg);
                left_next     = left_reg - 4'd1;
                last_next     = eom_reg && (left_reg == 4'd1);
                m_tvalid_next = 1'b1;
            end else if (pop_valid) begin
                pop_ready     = 1'b1;
                char_next     = sym_of(top_index(pop_item.data, pop_item.mode));
                shift_next    = shift_out(pop_item.data, pop_item.mode);
                left_next     = pop_item.nchar - 4'd1;
                mode_next     = pop_item.mode;
                eom_next      = pop_item.eom;
                last_next     = pop_item.eom && (pop_item.nchar == 4'd1);
                m_tvalid_next = 1'b1;
            end else begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            left_reg     <= left_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        mode_reg  <= mode_next;
        eom_reg   <= eom_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule

>>> design/base64_32_16_text_encoder_unit.sv
// top level of the unpadded base64/base32/base16 text encoder
// depends on b64e_pkg, b64e_front, b64e_queue and b64e_back
//
// Bytes enter on the s_ stream, one per cycle while s_tready is high, s_tlast on the final
// byte of a message; the encoded characters leave on the m_ stream, one per cycle while
// m_tready is high, m_tlast on the message's last character. The front end gathers a group
// (3 bytes base64, 5 base32, 1 base16) and hands it to a queue of QUEUE_DEPTH groups; the
// back end turns each group into 2 to 8 characters at one character per cycle while
// m_tready is high. The output character rate sets throughput, and a short group at a
// message end costs its own characters. A completed group goes into a queue slot, then its
// first character into the back end's output register. Write cfg_wr_data (0 base64,
// 1 base32, 2 base16) only while idle; a write drops any bytes gathered so far.

module base64_32_16_text_encoder_unit #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast    // last_char
);
    import b64e_pkg::*;

    logic push_valid, push_ready;
    grp_t push_item;
    logic pop_valid, pop_ready;
    grp_t pop_item;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    b64e_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    b64e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_item (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> design/b64e_checker.sv
// port-level checker for the text encoder top level, bound in below
// depends only on the top level's ports

module b64e_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic [7:0] open_reg, open_next;
    logic       in_end, out_end;

    assign in_end  = s_tvalid && s_tready && s_tlast;
    assign out_end = m_tvalid && m_tready && m_tlast;

    // messages whose end byte went in but whose last character has not come out
    always_comb begin
        open_next = open_reg;
        if (in_end && !out_end) begin
            open_next = open_reg + 8'd1;
        end else if (out_end && !in_end) begin
            open_next = open_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_alphabet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7] == 1'b0 && m_tdata >= 8'd43 && m_tdata <= 8'd122)
        else $error("output character outside the alphabet");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_last_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> open_reg != 8'd0)
        else $error("last character with no message end pending");

endmodule

bind base64_32_16_text_encoder_unit b64e_checker u_b64e_checker (.*);

>>> verif/tb_top.sv
// self-checking testbench for base64_32_16_text_encoder_unit: bytes in, characters out
// predicts every character and its last flag and compares them in order
// depends on b64e_pkg and the design top level

module tb_top;
    import b64e_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 26;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } enc_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
    logic       s_tlast = 1'b0;   // end_of_message
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] out_char, [7] zero
    logic       m_tlast;          // last_char

    logic [1:0]  enc_mode = MODE_B64;
    logic [31:0] held_bytes = 32'd0;
    int          held_count = 0;
    enc_char_t   exp_chars[$];

    int err_count = 0;
    int cycle_cnt = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    base64_32_16_text_encoder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [6:0] alpha_code(input logic [5:0] idx);
        logic [6:0] c;
        if (idx < 6'd26) begin
            c = 7'(8'h41 + idx);
        end else if (idx < 6'd52) begin
            c = 7'(8'h61 + idx - 26);
        end else if (idx < 6'd62) begin
            c = 7'(8'h30 + idx - 52);
        end else if (idx == 6'd62) begin
            c = 7'h2b;
        end else begin
            c = 7'h2f;
        end
        return c;
    endfunction

    // gather one byte and queue the characters it completes
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        int grp;
        int wid;
        int n;
        int nbits;
        int nchar;
        int sh;
        logic [63:0] acc;
        logic [5:0] idx;
        enc_char_t c;
        unique case (enc_mode)
            MODE_B64: begin grp = 3; wid = 6; end
            MODE_B32: begin grp = 5; wid = 5; end
            default:  begin grp = 1; wid = 4; end
        endcase
        n = held_count + 1;
        acc = ({32'd0, held_bytes} << 8) | {56'd0, b};
        if (n < grp && !eom) begin
            held_bytes = acc[31:0];
            held_count = n;
            return;
        end
        if (n > grp) n = grp;
        nbits = 8 * grp;
        acc = acc << (8 * (grp - n));
        acc = acc & ((64'd1 << nbits) - 64'd1);
        nchar = (8 * n + wid - 1) / wid;
        for (int i = 0; i < nchar; i++) begin
            sh = nbits - wid * (i + 1);
            idx = 6'((acc >> sh) & ((64'd1 << wid) - 64'd1));
            c.code = alpha_code(idx);
            c.last = eom && (i == nchar - 1);
            exp_chars.push_back(c);
        end
        held_bytes = 32'd0;
        held_count = 0;
    endtask

    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        enc_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_chars.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("char %02h last %0b with none expected", m_tdata, m_tlast);
            end else begin
                want = exp_chars.pop_front();
                if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("char mismatch: expected %02h last %0b, got %02h last %0b",
                                 {1'b0, want.code}, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_byte(b, eom);
        @(negedge aclk);
    endtask

    task automatic wait_drain;
        s_tvalid <= 1'b0;
        while (exp_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        enc_mode   = mode;
        held_bytes = 32'd0;
        held_count = 0;
    endtask

    task automatic test_reset_mode_b64;
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'haa, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hff, 1'b1);
    endtask

    task automatic test_b32_groups;
        wait_drain;
        write_mode(MODE_B32);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b1);
    endtask

    task automatic test_b16_and_spare;
        wait_drain;
        write_mode(MODE_B16);
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b0);
        wait_drain;
        write_mode(MODE_SPARE);
        send_item(8'h5a, 1'b1);
    endtask

    // pending bytes must be dropped by the mode write
    task automatic test_mode_write_mid_group;
        wait_drain;
        write_mode(MODE_B64);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        wait_drain;
        write_mode(MODE_B32);
        send_item(8'hc3, 1'b1);
    endtask

    task automatic run_phase(input logic [1:0] mode, input int tx_pct, input int rx_pct);
        int sent;
        int len;
        logic eom;
        wait_drain;
        write_mode(mode);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                // some messages lose their end mark and run into the next
                eom = (i == len - 1) && ($urandom_range(9) != 0);
                send_item(8'($urandom_range(255)), eom);
                sent++;
            end
        end
    endtask

    task automatic test_random_phases;
        run_phase(MODE_B64, 0, 0);
        run_phase(MODE_B32, 67, 0);
        run_phase(MODE_B16, 0, 67);
        run_phase(MODE_B64, 29, 29);
        run_phase(MODE_B32, 0, 0);
        run_phase(MODE_SPARE, 67, 0);
        run_phase(MODE_B64, 0, 67);
        run_phase(MODE_B32, 29, 29);
    endtask

    task automatic test_backpressure;
        wait_drain;
        write_mode(MODE_B32);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req = 300;
        for (int i = 0; i < 30; i++)
            send_item(8'($urandom_range(255)), i == 29);
        // sender waits for every char before going on
        wait_drain;
        tx_idle_pct  = 29;
        rx_stall_pct = 29;
        for (int i = 0; i < 10; i++)
            send_item(8'($urandom_range(255)), i == 9);
    endtask

    task automatic finish_run;
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (exp_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        err_count += exp_chars.size();
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_mode_b64;
        test_b32_groups;
        test_b16_and_spare;
        test_mode_write_mid_group;
        test_random_phases;
        test_backpressure;
        finish_run;
    end

endmodule

>>> files.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_32_16_text_encoder_unit.sv
design/b64e_checker.sv
verif/tb_top.sv
